/* hdl/rsa_pkg.sv */
// Shared types, codes and sizing constants for the reference-counted slot allocator.
// Used by rsa_ctrl, rsa_datapath, refcounted_slot_allocator, rsa_checker and testbench.
package rsa_pkg;

    localparam int RSA_SLOTS = 1024;
    localparam longint unsigned COUNT_MAX = 64'd65535;

    localparam int ID_W = 10;
    localparam int CNT_W = 16;
    localparam int STAT_W = 2;
    localparam int KIND_W = 2;

    localparam logic [CNT_W-1:0] COUNT_CAP =
        (COUNT_MAX > 64'd65535) ? 16'hFFFF : CNT_W'(COUNT_MAX);

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT     = 2'd3;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
    } rsa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } rsa_stat_t;

endpackage

/* hdl/refcounted_slot_allocator.sv */
// Top level of the reference-counted slot allocator with a LIFO free stack.
// Depends on rsa_pkg, rsa_ctrl and rsa_datapath.
//
//   Channel   Direction   Payload
//   s_*       in          tuser: kind; tdata: slot_id
//   m_*       out         tdata: result_slot, ref_count, status
//
// An accept step takes the item and reads the slot and stack memories; an execute
// step, once the result register is free, updates them and loads the result register.
// After reset a clearing pass wipes the valid marks of all min(SLOTS, 1024) entries;
// no input is accepted during it.
// A new input is accepted while a result waits; that item stalls in execution
// until the result register is taken.
module refcounted_slot_allocator
    import rsa_pkg::*;
#(
    parameter int SLOTS = RSA_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] slot_id, [15:10] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [9:0] result_slot, [25:10] ref_count, [27:26] status
);

    rsa_cmd_t          cmd;
    rsa_stat_t         stat;
    logic [ID_W-1:0]   out_slot;
    logic [CNT_W-1:0]  out_count;
    logic [STAT_W-1:0] out_status;

    rsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser),
        .in_id      (s_tdata[ID_W-1:0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_slot   (out_slot),
        .out_count  (out_count),
        .out_status (out_status)
    );

    assign m_tdata = {4'd0, out_status, out_count, out_slot};

endmodule

/* hdl/rsa_ctrl.sv */
// Controller state machine of the slot allocator: clearing pass, accept, execute.
// Depends on rsa_pkg; drives rsa_datapath through rsa_cmd_t and reads rsa_stat_t.
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  rsa_stat_t stat,
    output rsa_cmd_t  cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.clear   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/rsa_datapath.sv */
// Datapath of the slot allocator: valid, count and free-stack memories, the stack
// depth and bump counters, and the result register. Depends on rsa_pkg.
module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int SLOTS = RSA_SLOTS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsa_cmd_t          cmd,
    output rsa_stat_t         stat,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [ID_W-1:0]   in_id,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ID_W-1:0]   out_slot,
    output logic [CNT_W-1:0]  out_count,
    output logic [STAT_W-1:0] out_status
);

    localparam int TD      = (SLOTS < (1 << ID_W)) ? SLOTS : (1 << ID_W);
    localparam int TA_W    = $clog2(TD);
    localparam int SA_W    = $clog2(SLOTS);
    localparam int DEPTH_W = $clog2(SLOTS + 1);

    logic             valid_mem [TD];
    logic [CNT_W-1:0] count_mem [TD];
    logic [ID_W-1:0]  stack_mem [SLOTS];

    logic [TA_W-1:0]    clr_cnt_reg;
    logic [DEPTH_W-1:0] stack_depth_reg;
    logic [DEPTH_W-1:0] stack_depth_next;
    logic [DEPTH_W-1:0] fresh_reg;
    logic [DEPTH_W-1:0] fresh_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [ID_W-1:0]    id_reg;
    logic               valid_rd_reg;
    logic [CNT_W-1:0]   count_rd_reg;
    logic [ID_W-1:0]    stack_rd_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [ID_W-1:0]    slot_reg;
    logic [ID_W-1:0]    slot_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;

    logic [DEPTH_W-1:0] depth_dec;
    logic [SA_W-1:0]    pop_addr;
    logic               in_range;
    logic               vm_we;
    logic [TA_W-1:0]    vm_addr;
    logic               vm_wdata;
    logic               cm_we;
    logic [CNT_W-1:0]   cm_wdata;
    logic               sm_we;

    assign depth_dec = stack_depth_reg - DEPTH_W'(1);
    assign pop_addr  = depth_dec[SA_W-1:0];
    assign in_range  = (32'(id_reg) < 32'(SLOTS));

    assign stat.clear_last = (clr_cnt_reg == TA_W'(TD - 1));
    assign stat.out_free   = !m_valid_reg || m_tready;

    always_comb begin
        stack_depth_next = stack_depth_reg;
        fresh_next       = fresh_reg;
        slot_next        = id_reg;
        count_next       = '0;
        status_next      = ST_OK;
        vm_we            = 1'b0;
        vm_addr          = id_reg[TA_W-1:0];
        vm_wdata         = 1'b0;
        cm_we            = 1'b0;
        cm_wdata         = '0;
        sm_we            = 1'b0;
        if (cmd.clear) begin
            vm_we   = 1'b1;
            vm_addr = clr_cnt_reg;
        end else if (cmd.exec) begin
            if (kind_reg == KIND_ALLOC) begin
                if (stack_depth_reg != '0) begin
                    stack_depth_next = depth_dec;
                    slot_next        = stack_rd_reg;
                end else if (fresh_reg != DEPTH_W'(SLOTS)) begin
                    fresh_next = fresh_reg + DEPTH_W'(1);
                    slot_next  = ID_W'(fresh_reg);
                end else begin
                    slot_next   = '0;
                    status_next = ST_NO_FREE;
                end
            end else if (kind_reg == KIND_ADD || kind_reg == KIND_REMOVE) begin
                if (!in_range) begin
                    status_next = ST_EMPTY;
                end else if (kind_reg == KIND_ADD) begin
                    cm_we = 1'b1;
                    if (!valid_rd_reg) begin
                        vm_we    = 1'b1;
                        vm_wdata = 1'b1;
                        cm_wdata = CNT_W'(1);
                    end else if (count_rd_reg >= COUNT_CAP) begin
                        cm_wdata    = COUNT_CAP;
                        status_next = ST_SAT;
                    end else begin
                        cm_wdata = count_rd_reg + CNT_W'(1);
                    end
                    count_next = cm_wdata;
                end else begin
                    if (!valid_rd_reg) begin
                        status_next = ST_EMPTY;
                    end else if (count_rd_reg > CNT_W'(1)) begin
                        cm_we      = 1'b1;
                        cm_wdata   = count_rd_reg - CNT_W'(1);
                        count_next = cm_wdata;
                    end else begin
                        cm_we = 1'b1;
                        vm_we = 1'b1;
                        if (stack_depth_reg != DEPTH_W'(SLOTS)) begin
                            sm_we            = 1'b1;
                            stack_depth_next = stack_depth_reg + DEPTH_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (vm_we) begin
            valid_mem[vm_addr] <= vm_wdata;
        end
        if (cmd.capture) begin
            valid_rd_reg <= valid_mem[in_id[TA_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cm_we) begin
            count_mem[id_reg[TA_W-1:0]] <= cm_wdata;
        end
        if (cmd.capture) begin
            count_rd_reg <= count_mem[in_id[TA_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (sm_we) begin
            stack_mem[stack_depth_reg[SA_W-1:0]] <= id_reg;
        end
        if (cmd.capture) begin
            stack_rd_reg <= stack_mem[pop_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            id_reg   <= in_id;
        end
        if (cmd.exec) begin
            slot_reg   <= slot_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg     <= '0;
            stack_depth_reg <= '0;
            fresh_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + TA_W'(1);
            end
            stack_depth_reg <= stack_depth_next;
            fresh_reg       <= fresh_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign out_slot   = slot_reg;
    assign out_count  = count_reg;
    assign out_status = status_reg;

endmodule

/* sim/rsa_checker.sv */
`timescale 1ns / 100ps
// Result checker for the reference-counted slot allocator: watches both stream channels,
// keeps its own slot table, free-id stack and fresh-id counter, and compares every result.
// Depends on rsa_pkg.
module rsa_checker
    import rsa_pkg::*;
#(
    parameter int SLOTS = RSA_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [ID_W-1:0]   slot;
        logic [CNT_W-1:0]  refs;
        logic [STAT_W-1:0] status;
    } slot_reply_t;

    logic              slot_live [SLOTS];
    logic [CNT_W-1:0]  slot_refs [SLOTS];
    logic [ID_W-1:0]   freed_ids [SLOTS];
    int unsigned       freed_depth;
    int unsigned       next_fresh;
    slot_reply_t       expected_replies [$];
    int                mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function automatic slot_reply_t apply_slot_op(input logic [KIND_W-1:0] kind,
                                                  input logic [ID_W-1:0] id);
        slot_reply_t reply;
        reply.slot   = id;
        reply.refs   = '0;
        reply.status = ST_OK;
        case (kind)
            KIND_ALLOC: begin
                reply.slot = '0;
                if (freed_depth > 0) begin
                    freed_depth--;
                    reply.slot = freed_ids[freed_depth];
                end else if (next_fresh < SLOTS) begin
                    reply.slot = ID_W'(next_fresh);
                    next_fresh++;
                end else begin
                    reply.status = ST_NO_FREE;
                end
            end
            KIND_ADD: begin
                if (!slot_live[id]) begin
                    slot_live[id] = 1'b1;
                    slot_refs[id] = CNT_W'(1);
                end else if (slot_refs[id] >= COUNT_CAP) begin
                    slot_refs[id] = COUNT_CAP;
                    reply.status = ST_SAT;
                end else begin
                    slot_refs[id] = slot_refs[id] + 1'b1;
                end
                reply.refs = slot_refs[id];
            end
            KIND_REMOVE: begin
                if (!slot_live[id]) begin
                    reply.status = ST_EMPTY;
                end else if (slot_refs[id] > 1) begin
                    slot_refs[id] = slot_refs[id] - 1'b1;
                    reply.refs = slot_refs[id];
                end else begin
                    // The last reference is gone, so the id goes back on the stack.
                    slot_refs[id] = '0;
                    slot_live[id] = 1'b0;
                    if (freed_depth < SLOTS) begin
                        freed_ids[freed_depth] = id;
                        freed_depth++;
                    end
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge aclk) begin
        slot_reply_t want;
        logic [ID_W-1:0]   got_slot;
        logic [CNT_W-1:0]  got_refs;
        logic [STAT_W-1:0] got_status;
        got_slot   = m_tdata[ID_W-1:0];
        got_refs   = m_tdata[ID_W+CNT_W-1:ID_W];
        got_status = m_tdata[ID_W+CNT_W+STAT_W-1:ID_W+CNT_W];
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_live[i] = 1'b0;
            end
            freed_depth = 0;
            next_fresh = 0;
            expected_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing expected, slot %0d",
                                              got_slot));
                end else begin
                    want = expected_replies.pop_front();
                    if (got_slot != want.slot) begin
                        report_mismatch($sformatf("result_slot got %0d expected %0d",
                                                  got_slot, want.slot));
                    end
                    if (got_refs != want.refs) begin
                        report_mismatch($sformatf("ref_count of slot %0d got %0d expected %0d",
                                                  want.slot, got_refs, want.refs));
                    end
                    if (got_status != want.status) begin
                        report_mismatch($sformatf("status of slot %0d got %0d expected %0d",
                                                  want.slot, got_status, want.status));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_replies.insert(expected_replies.size(),
                                        apply_slot_op(s_tuser, s_tdata[ID_W-1:0]));
            end
        end
        fail_count <= mismatches;
        pending_count <= expected_replies.size();
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Top of the slot allocator testbench: clock, reset, bursty stimulus, receiver stalls
// and the verdict. Depends on rsa_pkg, refcounted_slot_allocator and rsa_checker.
module testbench;
    import rsa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int POOL_SIZE    = 8;
    localparam int RANDOM_OPS   = 350;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int          fail_count;
    int          pending_count;
    int          cycle_count;
    int          burst_left;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  pattern_bit = '0;
    int          pattern_left;

    refcounted_slot_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rsa_checker refcount_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver walks a 16-bit ready pattern that is redrawn now and then;
    // one draw in four is all ones so that long stall-free stretches occur.
    always @(posedge aclk) begin
        if (pattern_left == 0) begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom()) | 16'h0001);
            pattern_left <= $urandom_range(20, 200);
        end else begin
            m_tready <= ready_pattern[pattern_bit];
            pattern_bit <= pattern_bit + 1'b1;
            pattern_left <= pattern_left - 1;
        end
    end

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tuser <= 2'($urandom());
                s_tdata <= 16'($urandom());
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(16-ID_W){1'b0}}, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Most ids come from a small pool of busy slots, so that references pile up
    // and drain back to zero; the rest are spread over the whole table.
    task automatic random_ops(input int count);
        logic [ID_W-1:0]   hot_ids [POOL_SIZE];
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        int                roll;
        for (int p = 0; p < POOL_SIZE; p++) begin
            hot_ids[p] = ID_W'($urandom());
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 31) == 0) begin
                hot_ids[$urandom_range(0, POOL_SIZE - 1)] = ID_W'($urandom());
            end
            roll = $urandom_range(0, 99);
            if (roll < 18) begin
                kind = KIND_ALLOC;
            end else if (roll < 58) begin
                kind = KIND_ADD;
            end else if (roll < 95) begin
                kind = KIND_REMOVE;
            end else begin
                kind = KIND_UNUSED;
            end
            id = ($urandom_range(0, 6) == 0) ? ID_W'($urandom())
                                             : hot_ids[$urandom_range(0, POOL_SIZE - 1)];
            send_op(kind, id);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fresh ids, counting up and down, freeing, removal from an empty slot,
        // reuse of freed ids in last-in first-out order and the unused kind.
        send_op(KIND_ALLOC, 10'h3FF);
        send_op(KIND_ADD, 10'd0);
        send_op(KIND_ADD, 10'd0);
        send_op(KIND_REMOVE, 10'd0);
        send_op(KIND_REMOVE, 10'd0);
        send_op(KIND_REMOVE, 10'd0);
        send_op(KIND_ALLOC, 10'h2AA);
        send_op(KIND_ALLOC, 10'h155);
        send_op(KIND_ADD, 10'h3FF);
        send_op(KIND_ADD, 10'h3FF);
        send_op(KIND_REMOVE, 10'h3FF);
        send_op(KIND_REMOVE, 10'h3FF);
        send_op(KIND_REMOVE, 10'h3FF);
        send_op(KIND_ADD, 10'h2AA);
        send_op(KIND_REMOVE, 10'h2AA);
        send_op(KIND_ADD, 10'h155);
        send_op(KIND_REMOVE, 10'h155);
        send_op(KIND_ALLOC, 10'd0);
        send_op(KIND_UNUSED, 10'h3FF);
        send_op(KIND_UNUSED, 10'd0);
        send_op(KIND_ALLOC, 10'd0);
        send_op(KIND_ALLOC, 10'd0);
        send_op(KIND_ALLOC, 10'd0);
        send_op(KIND_REMOVE, 10'd512);

        // Use up every fresh id, then run into exhaustion.
        for (int i = 0; i < RSA_SLOTS + 4; i++) begin
            send_op(KIND_ALLOC, ID_W'($urandom()));
        end

        random_ops(RANDOM_OPS);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
